// File: rtl/ttc_eb_pkg.sv
// Shared constants, types and cosine table of the time-to-collision brake.
package ttc_eb_pkg;

  // Sizing of the scan and of the cosine table
  localparam int MAX_BEAMS       = 2048;
  localparam int COS_TABLE_DEPTH = 4096;
  localparam int BIDX_W          = $clog2(MAX_BEAMS);
  localparam int CIDX_W          = $clog2(COS_TABLE_DEPTH);
  localparam int QUARTER         = COS_TABLE_DEPTH / 4;
  // a few spare entries cover the last quadrant when the depth is not a multiple of four
  localparam int QTAB_N          = QUARTER + 4;
  localparam int QIDX_W          = $clog2(QTAB_N);

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int RANGE_W    = 16;
  localparam int TTC_W      = 16;
  localparam int ANGLE_W    = 12;
  localparam int STEP_W     = 8;
  localparam int COS_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SCL_W      = ANGLE_W + CIDX_W + 1;

  // Arithmetic widths
  localparam int RATE_W     = SPEED_W + COS_W + 1;
  localparam int PROD_W     = 26;
  localparam int REM_W      = 32;
  localparam int DIV_STEPS  = TTC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int RANGE_SCALE = 1000;
  localparam logic signed [SPEED_W-1:0] SPEED_FLOOR = 16'sd100;
  localparam logic [TTC_W-1:0] TTC_INF = '1;

  // Mirror points of the full table
  localparam logic [CIDX_W:0] K_Q1 = (CIDX_W+1)'(QUARTER);
  localparam logic [CIDX_W:0] K_Q2 = (CIDX_W+1)'(2 * QUARTER);
  localparam logic [CIDX_W:0] K_Q3 = (CIDX_W+1)'(3 * QUARTER);
  localparam logic [CIDX_W:0] K_D  = (CIDX_W+1)'(COS_TABLE_DEPTH);

  // Opcodes
  localparam logic OP_SPEED = 1'b0;
  localparam logic OP_BEAM  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TTC_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_speed;
    logic take_beam;
    logic angle;
    logic mul;
    logic check;
    logic div_step;
    logic update;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_beam;
    logic last;
    logic skip_div;
  } sts_t;

  // Cosine table, first quadrant, Q15 magnitude 0..32768
  typedef logic [COS_W-1:0] qcos_tab_t [QTAB_N];

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint COS_DENS [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};

  // Taylor series to x^12 in Q30, clamped and rounded to Q15
  function automatic qcos_tab_t build_qcos();
    qcos_tab_t tab;
    longint x;
    longint x2;
    longint t;
    for (int k = 0; k < QTAB_N; k++) begin
      x = (longint'(k) * Q30_HALF_PI) / QUARTER;
      x2 = (x * x) / Q30_ONE;
      t = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / COS_DENS[i];
      end
      if (t < 0) t = 0;
      if (t > Q30_ONE) t = Q30_ONE;
      tab[k] = COS_W'((t + 64'sd16384) >>> 15);
    end
    return tab;
  endfunction

  localparam qcos_tab_t QCOS_TAB = build_qcos();

endpackage

// File: rtl/ttc_eb_in_if.sv
// Input channel: speed updates and beam samples.
interface ttc_eb_in_if;
  import ttc_eb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [SPEED_W-1:0] speed_mm_s;
  logic [RANGE_W-1:0]        range_mm;
  logic                      range_bad;
  logic                      last_beam;

  modport source (output valid, output opcode, output speed_mm_s, output range_mm,
                  output range_bad, output last_beam, input ready);
  modport sink   (input valid, input opcode, input speed_mm_s, input range_mm,
                  input range_bad, input last_beam, output ready);
endinterface

// File: rtl/ttc_eb_out_if.sv
// Result channel: one brake decision per scan.
interface ttc_eb_out_if;
  import ttc_eb_pkg::*;

  logic             valid;
  logic             ready;
  logic             brake;
  logic [TTC_W-1:0] min_ttc_ms;
  logic             checked;

  modport source (output valid, output brake, output min_ttc_ms, output checked,
                  input ready);
  modport sink   (input valid, input brake, input min_ttc_ms, input checked,
                  output ready);
endinterface

// File: rtl/ttc_eb_cfg_if.sv
// Configuration write channel.
interface ttc_eb_cfg_if;
  import ttc_eb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ttc_eb_cos_rom.sv
// Quarter-wave cosine ROM with registered read.
module ttc_eb_cos_rom (
  input  logic                        clk,
  input  logic [ttc_eb_pkg::QIDX_W-1:0] addr,
  output logic [ttc_eb_pkg::COS_W-1:0]  data_r
);
  import ttc_eb_pkg::*;

  // Read one entry each cycle
  always_ff @(posedge clk) begin
    data_r <= QCOS_TAB[addr];
  end
endmodule

// File: rtl/ttc_eb_dp.sv
// Datapath: configuration, scan state, angle, rate multiply and shift-subtract divider.
module ttc_eb_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttc_eb_pkg::cmd_t                cmd,
  output ttc_eb_pkg::sts_t                sts,
  // request payload
  input  logic                            in_opcode,
  input  logic signed [ttc_eb_pkg::SPEED_W-1:0] in_speed_mm_s,
  input  logic [ttc_eb_pkg::RANGE_W-1:0]  in_range_mm,
  input  logic                            in_range_bad,
  input  logic                            in_last_beam,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [ttc_eb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttc_eb_pkg::CFG_DATA_W-1:0] cfg_data,
  // result payload
  output logic                            out_brake,
  output logic [ttc_eb_pkg::TTC_W-1:0]    out_min_ttc_ms,
  output logic                            out_checked
);
  import ttc_eb_pkg::*;

  // Configuration registers
  logic [TTC_W-1:0]   ttc_limit_ms_r;
  logic [RANGE_W-1:0] range_floor_mm_r;
  logic [RANGE_W-1:0] range_ceiling_mm_r;
  logic [ANGLE_W-1:0] start_angle_r;
  logic [STEP_W-1:0]  angle_step_r;

  // Scan state
  logic signed [SPEED_W-1:0] speed_now_r;
  logic signed [SPEED_W-1:0] scan_speed_r;
  logic [BIDX_W-1:0]         beam_index_r;
  logic [TTC_W-1:0]          running_min_r;

  // Per-beam working registers
  logic [RANGE_W-1:0]       range_r;
  logic                     invalid_r;
  logic                     last_r;
  logic [QIDX_W-1:0]        qidx_r;
  logic                     neg_r;
  logic signed [RATE_W-1:0] rate_r;
  logic [PROD_W-1:0]        prod_r;
  logic [REM_W-1:0]         rem_r;
  logic [TTC_W-1:0]         lo_r;
  logic [TTC_W-1:0]         quo_r;

  // Result registers
  logic             brake_r;
  logic [TTC_W-1:0] min_ttc_r;
  logic             checked_r;

  logic [COS_W-1:0]          cos_mag;
  logic signed [COS_W:0]     cos_s;
  logic [BIDX_W+STEP_W-1:0]  offs;
  logic [ANGLE_W-1:0]        angle;
  logic [SCL_W-1:0]          scaled;
  logic [CIDX_W:0]           kidx;
  logic [CIDX_W:0]           qsel;
  logic                      neg_sel;
  logic                      in_bad;
  logic                      rate_pos;
  logic                      sat;
  logic                      skip_div;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          divisor;
  logic                      ge;
  logic [TTC_W-1:0]          min_sel;
  logic                      checked_now;

  ttc_eb_cos_rom u_rom (
    .clk    (clk),
    .addr   (qidx_r),
    .data_r (cos_mag)
  );

  // Angle of the current beam, wrapped to one turn, then folded to the first quadrant
  always_comb begin
    offs   = beam_index_r * angle_step_r;
    angle  = start_angle_r + ANGLE_W'(offs);
    scaled = SCL_W'(angle) * SCL_W'(COS_TABLE_DEPTH);
    kidx   = {1'b0, CIDX_W'(scaled >> ANGLE_W)};
    if (kidx <= K_Q1) begin
      qsel = kidx;
      neg_sel = 1'b0;
    end else if (kidx <= K_Q2) begin
      qsel = K_Q2 - kidx;
      neg_sel = 1'b1;
    end else if (kidx <= K_Q3) begin
      qsel = kidx - K_Q2;
      neg_sel = 1'b1;
    end else begin
      qsel = K_D - kidx;
      neg_sel = 1'b0;
    end
  end

  // Range gate on the incoming request
  assign in_bad = in_range_bad || (in_range_mm < range_floor_mm_r) ||
                  (in_range_mm > range_ceiling_mm_r);

  assign cos_s = neg_r ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  // Beam is infinite, or the quotient would not fit in the result
  assign rate_pos = !rate_r[RATE_W-1] && (rate_r != '0);
  assign sat      = RATE_W'(prod_r[PROD_W-1:1]) >= $unsigned(rate_r);
  assign skip_div = invalid_r || !rate_pos || sat;

  // One restoring division step
  assign divisor = rate_r[REM_W-1:0];
  assign rem_sh  = {rem_r[REM_W-2:0], lo_r[TTC_W-1]};
  assign ge      = rem_sh >= divisor;

  assign min_sel     = (quo_r < running_min_r) ? quo_r : running_min_r;
  assign checked_now = scan_speed_r >= SPEED_FLOOR;

  assign sts.in_beam  = (in_opcode == OP_BEAM);
  assign sts.last     = last_r;
  assign sts.skip_div = skip_div;

  // Configuration and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttc_limit_ms_r     <= 16'd500;
      range_floor_mm_r   <= '0;
      range_ceiling_mm_r <= '1;
      start_angle_r      <= 12'hC00;
      angle_step_r       <= 8'd1;
      speed_now_r        <= '0;
      scan_speed_r       <= '0;
      beam_index_r       <= '0;
      running_min_r      <= TTC_INF;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TTC_LIMIT:   ttc_limit_ms_r     <= cfg_data;
          REG_RANGE_FLOOR: range_floor_mm_r   <= cfg_data;
          REG_RANGE_CEIL:  range_ceiling_mm_r <= cfg_data;
          REG_START_ANGLE: start_angle_r      <= cfg_data[ANGLE_W-1:0];
          REG_ANGLE_STEP:  angle_step_r       <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take_speed) begin
        speed_now_r <= in_speed_mm_s;
      end
      // latch the speed at the first beam of a scan
      if (cmd.take_beam && (beam_index_r == '0)) begin
        scan_speed_r <= speed_now_r;
      end
      if (cmd.update) begin
        running_min_r <= min_sel;
        if (!last_r && (beam_index_r != BIDX_W'(MAX_BEAMS - 1))) begin
          beam_index_r <= beam_index_r + 1'b1;
        end
      end
      if (cmd.emit) begin
        running_min_r <= TTC_INF;
        beam_index_r  <= '0;
      end
    end
  end

  // Per-beam pipeline and divider
  always_ff @(posedge clk) begin
    if (cmd.take_beam) begin
      range_r   <= in_range_mm;
      invalid_r <= in_bad;
      last_r    <= in_last_beam;
    end
    if (cmd.angle) begin
      qidx_r <= QIDX_W'(qsel);
      neg_r  <= neg_sel;
    end
    if (cmd.mul) begin
      rate_r <= scan_speed_r * cos_s;
      prod_r <= PROD_W'(range_r) * PROD_W'(RANGE_SCALE);
    end
    if (cmd.check) begin
      rem_r <= REM_W'(prod_r[PROD_W-1:1]);
      lo_r  <= {prod_r[0], {(TTC_W-1){1'b0}}};
      quo_r <= skip_div ? TTC_INF : '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? (rem_sh - divisor) : rem_sh;
      lo_r  <= {lo_r[TTC_W-2:0], 1'b0};
      quo_r <= {quo_r[TTC_W-2:0], ge};
    end
    if (cmd.emit) begin
      checked_r <= checked_now;
      brake_r   <= checked_now && (running_min_r < ttc_limit_ms_r);
      min_ttc_r <= running_min_r;
    end
  end

  assign out_brake      = brake_r;
  assign out_min_ttc_ms = min_ttc_r;
  assign out_checked    = checked_r;
endmodule

// File: rtl/ttc_eb_ctrl.sv
// Controller: sequences each beam through angle, table, multiply and divide steps.
module ttc_eb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ttc_eb_pkg::sts_t sts,
  output ttc_eb_pkg::cmd_t cmd
);
  import ttc_eb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_ROM,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        cmd.take_speed = accept && !sts.in_beam;
        cmd.take_beam  = accept && sts.in_beam;
        if (accept && sts.in_beam) begin
          state_nxt = S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = S_ROM;
      end
      S_ROM: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.skip_div ? S_UPDATE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// File: rtl/ttc_emergency_brake.sv
// Speed update: taken while idle; the block stays ready for the next request.
// Beam: angle, table, multiply, check, 16-step shift-subtract divide and update;
// the divider is skipped when the beam is invalid, receding or saturates. The
// last beam of a scan then loads the result register once it is free, and the
// result waits to be taken while new requests are accepted.
// Synchronous active-low reset restores the register defaults and clears the scan.
module ttc_emergency_brake (
  input  logic         clk,
  input  logic         rst_n,
  ttc_eb_in_if.sink    in_chan,
  ttc_eb_out_if.source out_chan,
  ttc_eb_cfg_if.sink   cfg_chan
);
  import ttc_eb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  ttc_eb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttc_eb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_chan.opcode),
    .in_speed_mm_s  (in_chan.speed_mm_s),
    .in_range_mm    (in_chan.range_mm),
    .in_range_bad   (in_chan.range_bad),
    .in_last_beam   (in_chan.last_beam),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .out_brake      (out_chan.brake),
    .out_min_ttc_ms (out_chan.min_ttc_ms),
    .out_checked    (out_chan.checked)
  );

`ifndef SYNTHESIS
  // A beam request occupies the sequencer for the next cycle
  a_beam_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready && (in_chan.opcode == OP_BEAM) |=> !in_ready)
    else $error("ready high right after a beam request");

  // A speed update never stalls the input
  a_speed_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready && (in_chan.opcode == OP_SPEED) |=> in_ready)
    else $error("ready dropped after a speed update");

  // The result register is only loaded when the previous result has gone
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_chan.ready))
    else $error("result overwritten before it was taken");

  // Divider steps and result loading never coincide with a new request
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.emit) |-> !in_ready)
    else $error("request accepted while a beam is in flight");
`endif
endmodule
